// ===== hdl/hri_pkg.sv =====
package hri_pkg;

    localparam int RADIX_BITS  = 6;
    localparam int INDEX_WIDTH = 32;
    localparam int OUT_BITS    = 32;
    localparam int DIGIT_STEPS = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIGIT = 4'b0010,
        ST_FRAC  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [RADIX_BITS-1:0]  rem;
        logic [DIGIT_STEPS-1:0] quo;
    } digit_res_t;

endpackage

// ===== hdl/hri_digit_step.sv =====
module hri_digit_step (
    input  logic [hri_pkg::RADIX_BITS-1:0]  rem_in,
    input  logic [hri_pkg::DIGIT_STEPS-1:0] chunk,
    input  logic [hri_pkg::RADIX_BITS-1:0]  radix,
    output hri_pkg::digit_res_t             res
);
    import hri_pkg::*;

    logic [RADIX_BITS:0]    trial;
    logic [RADIX_BITS-1:0]  r;
    logic [DIGIT_STEPS-1:0] q;

    // restoring division of a byte by the radix, remainder stays narrow
    always_comb
    begin
        r     = rem_in;
        q     = '0;
        trial = '0;
        for (int i = DIGIT_STEPS - 1; i >= 0; i--)
        begin
            trial = {r, chunk[i]};
            if (trial >= {1'b0, radix})
            begin
                trial = trial - {1'b0, radix};
                q[i]  = 1'b1;
            end
            r = trial[RADIX_BITS-1:0];
        end
        res.rem = r;
        res.quo = q;
    end

endmodule

// ===== hdl/hri_frac_step.sv =====
module hri_frac_step #(
    parameter int WIDTH = 38
) (
    input  logic [WIDTH-1:0] rem_in,
    input  logic [WIDTH-1:0] den,
    output logic [WIDTH-1:0] rem_out,
    output logic             bit_out
);
    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;

    // one bit of long division, remainder stays below den while rem_in is below den
    always_comb
    begin
        shifted = {rem_in, 1'b0};
        diff    = shifted - {1'b0, den};
        bit_out = (shifted >= {1'b0, den});
        rem_out = bit_out ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end

endmodule

// ===== hdl/halton_radical_inverse.sv =====
// each digit runs through the byte-serial radix divider, the fraction through a
// one-bit-per-cycle long divider; one request in flight, the next accepted once the
// result is registered; reset clears the sequencer and the output valid; no state survives a request
module halton_radical_inverse #(
    parameter int INDEX_BITS    = 32,
    parameter int FRACTION_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hri_pkg::INDEX_WIDTH-1:0]   point_index,
    input  logic [hri_pkg::RADIX_BITS-1:0]    radix,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hri_pkg::OUT_BITS-1:0]      fraction
);
    import hri_pkg::*;

    localparam int PASSES = (INDEX_BITS + DIGIT_STEPS - 1) / DIGIT_STEPS;
    localparam int NW     = PASSES * DIGIT_STEPS;
    localparam int DW     = INDEX_BITS + RADIX_BITS;
    localparam int PCW    = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int FCW    = $clog2(FRACTION_BITS);

    state_t                   state_reg, state_next;
    logic [PCW-1:0]           pass_cnt_reg, pass_cnt_next;
    logic [FCW-1:0]           frac_cnt_reg, frac_cnt_next;
    logic                     pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;

    logic [NW-1:0]            n_reg, n_next;
    logic [RADIX_BITS-1:0]    b_reg, b_next;
    logic [RADIX_BITS-1:0]    rem_reg, rem_next;
    logic [RADIX_BITS-1:0]    dig_reg, dig_next;
    logic [DW-1:0]            rev_reg, rev_next;
    logic [DW-1:0]            den_reg, den_next;
    logic [FRACTION_BITS-1:0] q_reg, q_next;
    logic [OUT_BITS-1:0]      fraction_reg, fraction_next;

    logic [NW+INDEX_WIDTH-1:0]   idx_wide;
    logic [INDEX_BITS-1:0]       idx_masked;
    logic [NW+INDEX_BITS-1:0]    idx_pad;
    logic [OUT_BITS+FRACTION_BITS-1:0] q_pad;
    logic [NW+DIGIT_STEPS-1:0]   n_shift;

    logic                     accept;
    logic                     pass_last;
    logic                     frac_last;
    logic [RADIX_BITS-1:0]    step_rem_in;
    digit_res_t               step_res;
    logic [DW+RADIX_BITS-1:0] rev_prod;
    logic [DW+RADIX_BITS-1:0] den_prod;
    logic [DW-1:0]            frac_rem;
    logic                     frac_bit;

    assign idx_wide   = {{NW{1'b0}}, point_index};
    assign idx_masked = idx_wide[INDEX_BITS-1:0];
    assign idx_pad    = {{NW{1'b0}}, idx_masked};
    assign q_pad      = {{OUT_BITS{1'b0}}, q_reg};

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign fraction  = fraction_reg;

    assign pass_last = (pass_cnt_reg == PCW'(PASSES - 1));
    assign frac_last = (frac_cnt_reg == FCW'(FRACTION_BITS - 1));

    // remainder restarts at zero with the top byte of each digit division
    assign step_rem_in = (pass_cnt_reg == '0) ? '0 : rem_reg;

    hri_digit_step u_digit (
        .rem_in (step_rem_in),
        .chunk  (n_reg[NW-1 -: DIGIT_STEPS]),
        .radix  (b_reg),
        .res    (step_res)
    );

    hri_frac_step #(
        .WIDTH (DW)
    ) u_frac (
        .rem_in  (rev_reg),
        .den     (den_reg),
        .rem_out (frac_rem),
        .bit_out (frac_bit)
    );

    assign n_shift  = {n_reg, step_res.quo};
    assign rev_prod = {{RADIX_BITS{1'b0}}, rev_reg} * {{DW{1'b0}}, b_reg}
                    + {{DW{1'b0}}, dig_reg};
    assign den_prod = {{RADIX_BITS{1'b0}}, den_reg} * {{DW{1'b0}}, b_reg};

    always_comb
    begin
        state_next     = state_reg;
        pass_cnt_next  = pass_cnt_reg;
        frac_cnt_next  = frac_cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        dig_next       = dig_reg;
        rev_next       = rev_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        fraction_next  = fraction_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next        = idx_pad[NW-1:0];
                    b_next        = (radix < RADIX_MIN) ? RADIX_MIN : radix;
                    rev_next      = '0;
                    den_next      = DW'(1);
                    pend_next     = 1'b0;
                    pass_cnt_next = '0;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (pass_cnt_reg == '0)
                begin
                    // fold in the digit from the previous division
                    if (pend_reg)
                    begin
                        rev_next = rev_prod[DW-1:0];
                        den_next = den_prod[DW-1:0];
                    end
                    pend_next = 1'b0;
                end
                if (pass_cnt_reg == '0 && n_reg == '0)
                begin
                    frac_cnt_next = '0;
                    q_next        = '0;
                    state_next    = ST_FRAC;
                end
                else
                begin
                    n_next   = n_shift[NW-1:0];
                    rem_next = step_res.rem;
                    if (pass_last)
                    begin
                        dig_next      = step_res.rem;
                        pend_next     = 1'b1;
                        pass_cnt_next = '0;
                    end
                    else
                    begin
                        pass_cnt_next = pass_cnt_reg + PCW'(1);
                    end
                end
            end
            ST_FRAC:
            begin
                rev_next = frac_rem;
                q_next   = {q_reg[FRACTION_BITS-2:0], frac_bit};
                if (frac_last)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    frac_cnt_next = frac_cnt_reg + FCW'(1);
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fraction_next  = q_pad[OUT_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_cnt_reg  <= '0;
            frac_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_cnt_reg  <= pass_cnt_next;
            frac_cnt_reg  <= frac_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        b_reg        <= b_next;
        rem_reg      <= rem_next;
        dig_reg      <= dig_next;
        rev_reg      <= rev_next;
        den_reg      <= den_next;
        q_reg        <= q_next;
        fraction_reg <= fraction_next;
    end

    // partial remainder of the digit division never reaches the radix
    a_rem_below_radix : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && pass_cnt_reg != '0) |-> rem_reg < b_reg)
        else $error("digit remainder not below radix");

    // mirrored numerator stays below radix^k through the fraction division
    a_rev_below_den : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAC) |-> (rev_reg < den_reg))
        else $error("fraction remainder not below denominator");

    // an exhausted index with no pending digit goes straight to the fraction
    a_zero_to_frac : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && pass_cnt_reg == '0 && n_reg == '0 && !pend_reg)
        |=> (state_reg == ST_FRAC && frac_cnt_reg == '0))
        else $error("digit loop did not hand over to fraction division");

    // clamped radix is at least two while a request is in flight
    a_radix_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (b_reg >= RADIX_MIN))
        else $error("radix below two in digit loop");

endmodule

// ===== tb/tb_halton_radical_inverse.sv =====
`timescale 1ns / 1ps

module tb_halton_radical_inverse;

    import hri_pkg::*;

    localparam int FRAC_BITS   = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DRAIN_TICKS = 200;

    typedef struct {
        logic [INDEX_WIDTH-1:0] point;
        logic [RADIX_BITS-1:0]  base;
        logic [OUT_BITS-1:0]    fraction;
    } pending_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [INDEX_WIDTH-1:0] point_index = '0;
    logic [RADIX_BITS-1:0]  radix       = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [OUT_BITS-1:0]    fraction;

    pending_t    expected_fractions[$];
    pending_t    oldest;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    halton_radical_inverse DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_index (point_index),
        .radix       (radix),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fraction    (fraction)
    );

    always #5 clk = ~clk;

    // digits are folded back from the most significant one, so every
    // truncation lands on the exact floor of the mirrored value
    function automatic logic [OUT_BITS-1:0] radical_inverse_q32(
        input logic [INDEX_WIDTH-1:0] idx,
        input logic [RADIX_BITS-1:0]  rdx
    );
        logic [63:0]           base;
        logic [63:0]           rest;
        logic [63:0]           acc;
        logic [RADIX_BITS-1:0] digit_stack [0:MAX_DIGITS-1];
        int unsigned           depth;
        base  = (rdx < RADIX_MIN) ? 64'(RADIX_MIN) : 64'(rdx);
        rest  = 64'(idx);
        acc   = '0;
        depth = 0;
        while (rest != 0)
        begin
            digit_stack[depth] = RADIX_BITS'(rest % base);
            rest = rest / base;
            depth++;
        end
        while (depth > 0)
        begin
            depth--;
            acc = ((64'(digit_stack[depth]) << FRAC_BITS) + acc) / base;
        end
        return acc[OUT_BITS-1:0];
    endfunction

    task automatic send_request(
        input logic [INDEX_WIDTH-1:0] idx,
        input logic [RADIX_BITS-1:0]  rdx
    );
        pending_t req;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        point_index <= idx;
        radix       <= rdx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        req.point    = idx;
        req.base     = rdx;
        req.fraction = radical_inverse_q32(idx, rdx);
        expected_fractions.insert(expected_fractions.size(), req);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fractions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected fraction %h with no request pending", fraction);
            end
            else
            begin
                oldest = expected_fractions.pop_front();
                if (fraction !== oldest.fraction)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("index %h radix %0d: expected fraction %h, got %h",
                                 oldest.point, oldest.base, oldest.fraction, fraction);
                end
            end
        end
    end

    task automatic test_zero_index();
        send_request(32'h0, 6'd2);
        send_request(32'h0, 6'd63);
        send_request(32'h0, 6'd0);
        send_request(32'h0, 6'd17);
    endtask

    // radix 0 and 1 behave as radix 2
    task automatic test_radix_clamp();
        send_request(32'h1, 6'd0);
        send_request(32'h1, 6'd1);
        send_request(32'hFFFF_FFFF, 6'd0);
        send_request(32'hDEAD_BEEF, 6'd1);
        send_request(32'h5, 6'd1);
    endtask

    task automatic test_field_extremes();
        send_request(32'h1, 6'd2);
        send_request(32'hFFFF_FFFF, 6'd2);
        send_request(32'hFFFF_FFFF, 6'd63);
        send_request(32'h8000_0000, 6'd2);
        send_request(32'd62, 6'd63);
        send_request(32'd63, 6'd63);
        send_request(32'h1, 6'd3);
        // 3^20 and one below it: a lone top digit versus all digits at maximum
        send_request(32'd3486784401, 6'd3);
        send_request(32'd3486784400, 6'd3);
        send_request(32'h5555_5555, 6'd61);
        send_request(32'hAAAA_AAAA, 6'd37);
    endtask

    task automatic run_random_phase(
        input int unsigned count,
        input int unsigned idle_pct,
        input int unsigned stall_pct
    );
        logic [INDEX_WIDTH-1:0] idx;
        logic [RADIX_BITS-1:0]  rdx;
        int unsigned            pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0:       idx = $urandom;
                1:       idx = $urandom >> $urandom_range(0, 31);
                2:       idx = $urandom_range(0, 255);
                default: idx = $urandom >> $urandom_range(16, 31);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 5)
                rdx = RADIX_BITS'($urandom_range(0, 1));
            else if (pick < 35)
            begin
                case ($urandom_range(0, 5))
                    0:       rdx = 6'd2;
                    1:       rdx = 6'd3;
                    2:       rdx = 6'd5;
                    3:       rdx = 6'd7;
                    4:       rdx = 6'd11;
                    default: rdx = 6'd13;
                endcase
            end
            else
                rdx = RADIX_BITS'($urandom_range(2, 63));
            send_request(idx, rdx);
        end
    endtask

    task automatic test_random_points();
        run_random_phase(240, 0, 0);
        run_random_phase(240, 75, 0);
        run_random_phase(240, 0, 75);
        run_random_phase(240, 19, 19);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_index();
        test_radix_clamp();
        test_field_extremes();
        test_random_points();

        in_valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
